// File: src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared widths, constants and register codes of the spectrum band mean block.
// ----------------------------------------------------------------------------
package sbm_pkg;

    // default largest fft length
    localparam int MAX_FFT_SIZE_DEF = 1024;

    // port field widths
    localparam int MAG_W      = 32;
    localparam int IDX_W      = 9;
    localparam int LVL_W      = 16;
    localparam int FFTL_W     = 4;
    localparam int BAND_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // log2 fixed point format and normalized mantissa width
    localparam int LOG_FRAC = 20;
    localparam int MANT_W   = 32;

    // 20*log10(2) in unsigned q.24, product shift back to q8.8
    localparam int                DBK_W    = 27;
    localparam logic [DBK_W-1:0]  DB_K     = 27'd101008905;
    localparam int                DB_SHIFT = 36;

    // fraction bits of the q16.16 magnitude
    localparam int SPEC_OFFSET = 16;

    // register reset values and clamp floor
    localparam logic [FFTL_W-1:0] FFT_LOG2_RST   = 4'd8;
    localparam logic [FFTL_W-1:0] FFT_LOG2_MIN   = 4'd3;
    localparam logic [BAND_W-1:0] BAND_COUNT_RST = 10'd16;

    // saturation limits of the q8.8 level
    localparam logic [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FFT_SIZE_LOG2 = 2'd0,
        REG_BAND_COUNT    = 2'd1
    } t_reg_idx;

endpackage

// File: src/sbm_div.sv
// ----------------------------------------------------------------------------
// sbm_div
// Restoring divider, one quotient bit per cycle, used for the band edges.
// ----------------------------------------------------------------------------
module sbm_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    // shift in the next numerator bit and try the subtract
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/sbm_log2.sv
// ----------------------------------------------------------------------------
// sbm_log2
// Fixed point log2: stepwise normalize, then one squaring per fraction bit.
// ----------------------------------------------------------------------------
module sbm_log2 #(
    parameter int IN_W = 41
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [IN_W-1:0]                            i_x,
    output logic                                       o_done,
    output logic [$clog2(IN_W)+sbm_pkg::LOG_FRAC-1:0]  o_log
);

    import sbm_pkg::*;

    localparam int E_W   = $clog2(IN_W);
    localparam int LOG_W = E_W + LOG_FRAC;
    localparam int CNT_W = $clog2(LOG_FRAC + 1);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } t_lstate;

    t_lstate              r_state;
    logic [IN_W-1:0]      r_x;
    logic [E_W-1:0]       r_e;
    logic [E_W-1:0]       r_sh;
    logic [MANT_W-1:0]    r_m;
    logic [LOG_FRAC-1:0]  r_frac;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;
    logic [LOG_W-1:0]     r_log;

    logic                 w_top_zero;
    logic [IN_W-1:0]      w_x_next;
    logic [E_W-1:0]       w_e_next;
    logic [2*MANT_W-1:0]  w_sq;
    logic [MANT_W:0]      w_t;
    logic                 w_bit;
    logic [MANT_W-1:0]    w_m_next;

    // normalize step: shift left by r_sh when the top r_sh bits are clear
    assign w_top_zero = ((r_x & ~({IN_W{1'b1}} >> r_sh)) == '0);
    assign w_x_next   = w_top_zero ? (r_x << r_sh) : r_x;
    assign w_e_next   = w_top_zero ? (r_e - r_sh) : r_e;

    // squaring step: m*m back to [1,4), one fraction bit out
    assign w_sq     = r_m * r_m;
    assign w_t      = w_sq[2*MANT_W-1:MANT_W-1];
    assign w_bit    = w_t[MANT_W];
    assign w_m_next = w_bit ? w_t[MANT_W:1] : w_t[MANT_W-1:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_sh    <= '0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_NORM;
                        r_sh    <= E_W'(1) << (E_W - 1);
                    end
                end
                L_NORM: begin
                    r_sh <= r_sh >> 1;
                    if (r_sh == E_W'(1)) begin
                        r_state <= L_SQ;
                        r_cnt   <= CNT_W'(LOG_FRAC);
                    end
                end
                L_SQ: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_x <= i_x;
            r_e <= E_W'(IN_W - 1);
        end else if (r_state == L_NORM) begin
            r_x <= w_x_next;
            r_e <= w_e_next;
            r_m <= w_x_next[IN_W-1 -: MANT_W];
        end else if (r_state == L_SQ) begin
            r_m    <= w_m_next;
            r_frac <= {r_frac[LOG_FRAC-2:0], w_bit};
            if (r_cnt == CNT_W'(1)) begin
                r_log <= {r_e, r_frac[LOG_FRAC-2:0], w_bit};
            end
        end
    end

    assign o_done = r_done;
    assign o_log  = r_log;

endmodule

// File: src/spectrum_band_mean_db.sv
// A bin that closes no band is taken with no stall; o_ready stays high.
// A band close holds o_ready low, plus any output stall, through these steps:
// two log2 passes on the shared squaring unit, one scaling multiply, one output
// load and an edge division; a zero band sum skips both log2 passes, and a bin
// closing two bands goes through the report steps twice.
// Reset is synchronous and active low; o_ready rises once the first edge division after it is done.
// ----------------------------------------------------------------------------
// spectrum_band_mean_db
// Averages streamed fft magnitudes over bands and reports each mean in q8.8 dB.
// ----------------------------------------------------------------------------
module spectrum_band_mean_db #(
    parameter int MAX_FFT_SIZE = sbm_pkg::MAX_FFT_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // magnitude input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sbm_pkg::MAG_W-1:0]           i_magnitude,
    // band result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sbm_pkg::IDX_W-1:0]           o_band_index,
    output logic signed [sbm_pkg::LVL_W-1:0]    o_level_db,
    output logic                                o_level_zero,
    output logic                                o_last_band,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import sbm_pkg::*;

    localparam int ML    = $clog2(MAX_FFT_SIZE + 1) - 1;
    localparam int BIN_W = ML;
    localparam int NUM_W = 2 * ML - 1;
    localparam int SUM_W = MAG_W + ML - 1;
    localparam int E_W   = $clog2(SUM_W);
    localparam int LOG_W = E_W + LOG_FRAC;
    localparam int L_W   = LOG_W + 2;
    localparam int K_W   = DBK_W + 1;
    localparam int P_W   = L_W + K_W;
    localparam int R_W   = P_W - DB_SHIFT;
    localparam int BW    = (ML > BAND_W) ? ML : BAND_W;

    localparam logic [FFTL_W-1:0]     LG_MAX = FFTL_W'(ML);
    localparam logic signed [L_W-1:0] L_OFS  = L_W'(SPEC_OFFSET * (2 ** LOG_FRAC));
    localparam logic signed [K_W-1:0] K_S    = {1'b0, DB_K};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_LOGS  = 6'b000100,
        S_LOGC  = 6'b001000,
        S_SCALE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        AFT_IDLE    = 2'd0,
        AFT_NEXT    = 2'd1,
        AFT_RESTART = 2'd2
    } t_after;

    // control and frame state
    t_state              r_state, n_state;
    t_after              r_after, n_after;
    logic                r_pend, n_pend;
    logic                r_div_restart, n_div_restart;
    logic                r_div_start, n_div_start;
    logic                r_log_start, n_log_start;
    logic                r_o_valid, n_o_valid;
    logic [FFTL_W-1:0]   r_fft_log2, n_fft_log2;
    logic [BAND_W-1:0]   r_band_count, n_band_count;
    logic [BIN_W-1:0]    r_bin, n_bin;
    logic [BIN_W-1:0]    r_band, n_band;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [BIN_W-1:0]    r_low, n_low;
    logic [BIN_W-1:0]    r_high, n_high;

    // band being reported and its arithmetic
    logic [BIN_W-1:0]    r_e_idx;
    logic [SUM_W-1:0]    r_e_sum;
    logic [BIN_W-1:0]    r_e_cnt;
    logic                r_e_zero;
    logic                r_e_last;
    logic [LOG_W-1:0]    r_log_s;
    logic signed [L_W-1:0] r_l;
    logic signed [P_W-1:0] r_prod;

    // output register
    logic [IDX_W-1:0]    r_o_idx;
    logic [LVL_W-1:0]    r_o_level;
    logic                r_o_zero;
    logic                r_o_last;

    logic [FFTL_W-1:0]   w_lg;
    logic [FFTL_W-1:0]   w_half_sh;
    logic [BIN_W-1:0]    w_half;
    logic [BW-1:0]       w_bc;
    logic [BW-1:0]       w_bc1;
    logic [BW-1:0]       w_bands_bw;
    logic [BIN_W-1:0]    w_bands;

    logic                w_acc;
    logic [SUM_W-1:0]    w_add;
    logic [SUM_W-1:0]    w_sum_new;
    logic                w_close;
    logic                w_last;
    logic [BIN_W-1:0]    w_cnt_cur;

    logic [BIN_W-1:0]    w_div_k;
    logic [NUM_W-1:0]    w_div_num;
    logic                w_div_done;
    logic [NUM_W-1:0]    w_quot;
    logic [BIN_W-1:0]    w_edge;
    logic [BIN_W-1:0]    w_cnt_div;

    logic [SUM_W-1:0]    w_log_x;
    logic                w_log_done;
    logic [LOG_W-1:0]    w_log_res;

    logic                w_neg;
    logic [P_W-1:0]      w_mag;
    logic [P_W-1:0]      w_rnd_full;
    logic [R_W-1:0]      w_rnd;
    logic [LVL_W-1:0]    w_level;

    logic                w_em_load;
    logic [BIN_W-1:0]    w_em_idx;
    logic [SUM_W-1:0]    w_em_sum;
    logic [BIN_W-1:0]    w_em_cnt;
    logic                w_em_last;
    logic                w_em_zero;
    logic                w_out_load;
    logic                w_restart;

    // effective fft size and band count after clamping
    always_comb begin
        if (r_fft_log2 < FFT_LOG2_MIN) begin
            w_lg = FFT_LOG2_MIN;
        end else if (r_fft_log2 > LG_MAX) begin
            w_lg = LG_MAX;
        end else begin
            w_lg = r_fft_log2;
        end
    end

    assign w_half_sh  = w_lg - FFTL_W'(1);
    assign w_half     = BIN_W'(1) << w_half_sh;
    assign w_bc       = BW'(r_band_count);
    assign w_bc1      = (w_bc == '0) ? BW'(1) : w_bc;
    assign w_bands_bw = (w_bc1 > BW'(w_half)) ? BW'(w_half) : w_bc1;
    assign w_bands    = BIN_W'(w_bands_bw);

    // per-bin accumulate and band close decisions
    assign w_acc     = i_valid && o_ready;
    assign w_add     = (r_bin != '0) ? SUM_W'(i_magnitude) : '0;
    assign w_sum_new = r_sum + w_add;
    assign w_close   = (({1'b0, r_band} + (BIN_W+1)'(1)) < {1'b0, w_bands})
                       && (r_bin == r_high);
    assign w_last    = (({1'b0, r_bin} + (BIN_W+1)'(1)) >= {1'b0, w_half});
    assign w_cnt_cur = r_high - r_low + BIN_W'(1);

    // next band edge: k * half / bands
    assign w_div_k   = r_div_restart ? BIN_W'(1) : (r_band + BIN_W'(1));
    assign w_div_num = NUM_W'(w_div_k) << w_half_sh;
    assign w_edge    = BIN_W'(w_quot);
    assign w_cnt_div = w_edge - r_low + BIN_W'(1);

    sbm_div #(
        .NUM_W (NUM_W),
        .DEN_W (BIN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_div_num),
        .i_den   (w_bands),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // log2 of band sum, then of bin count, on the one unit
    assign w_log_x = (r_state == S_LOGS) ? r_e_sum : SUM_W'(r_e_cnt);

    sbm_log2 #(
        .IN_W (SUM_W)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_log_start),
        .i_x     (w_log_x),
        .o_done  (w_log_done),
        .o_log   (w_log_res)
    );

    // round half away from zero and saturate to q8.8
    assign w_neg      = r_prod[P_W-1];
    assign w_mag      = w_neg ? P_W'(-r_prod) : P_W'(r_prod);
    assign w_rnd_full = w_mag + (P_W'(1) << (DB_SHIFT - 1));
    assign w_rnd      = w_rnd_full[P_W-1:DB_SHIFT];

    always_comb begin
        if (r_e_zero) begin
            w_level = LVL_MIN;
        end else if (!w_neg) begin
            w_level = (w_rnd > R_W'(LVL_MAX)) ? LVL_MAX : w_rnd[LVL_W-1:0];
        end else begin
            w_level = (w_rnd > R_W'(LVL_MIN)) ? LVL_MIN : (-w_rnd[LVL_W-1:0]);
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_after       = r_after;
        n_pend        = r_pend;
        n_div_restart = r_div_restart;
        n_div_start   = 1'b0;
        n_log_start   = 1'b0;
        n_fft_log2    = r_fft_log2;
        n_band_count  = r_band_count;
        n_bin         = r_bin;
        n_band        = r_band;
        n_sum         = r_sum;
        n_low         = r_low;
        n_high        = r_high;
        w_em_load     = 1'b0;
        w_em_idx      = r_band;
        w_em_sum      = w_sum_new;
        w_em_cnt      = w_cnt_cur;
        w_em_last     = 1'b0;
        w_out_load    = 1'b0;
        w_restart     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_close) begin
                        // close this band, the edge bin opens the next one
                        w_em_load = 1'b1;
                        n_band    = r_band + BIN_W'(1);
                        n_low     = r_high;
                        n_sum     = w_add;
                        n_bin     = r_bin + BIN_W'(1);
                        n_pend    = w_last;
                        n_after   = AFT_NEXT;
                    end else if (w_last) begin
                        w_em_load = 1'b1;
                        w_em_last = 1'b1;
                        n_after   = AFT_RESTART;
                    end else begin
                        n_sum = w_sum_new;
                        n_bin = r_bin + BIN_W'(1);
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_high = w_edge;
                    if (!r_div_restart && r_pend) begin
                        // end of frame right after a band close
                        w_em_load = 1'b1;
                        w_em_sum  = r_sum;
                        w_em_cnt  = w_cnt_div;
                        w_em_last = 1'b1;
                        n_pend    = 1'b0;
                        n_after   = AFT_RESTART;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOGS: begin
                if (w_log_done) begin
                    n_state     = S_LOGC;
                    n_log_start = 1'b1;
                end
            end
            S_LOGC: begin
                if (w_log_done) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    w_out_load = 1'b1;
                    case (r_after)
                        AFT_NEXT: begin
                            n_state       = S_DIV;
                            n_div_start   = 1'b1;
                            n_div_restart = 1'b0;
                        end
                        AFT_RESTART: begin
                            w_restart = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a zero sum skips the logs
        w_em_zero = (w_em_sum == '0);
        if (w_em_load) begin
            if (w_em_zero) begin
                n_state = S_OUT;
            end else begin
                n_state     = S_LOGS;
                n_log_start = 1'b1;
            end
        end

        // register writes drop the frame in progress
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FFT_SIZE_LOG2: begin
                    n_fft_log2 = i_cfg_data[FFTL_W-1:0];
                    w_restart  = 1'b1;
                end
                REG_BAND_COUNT: begin
                    n_band_count = i_cfg_data[BAND_W-1:0];
                    w_restart    = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // new frame: clear counters and divide out the first edge
        if (w_restart) begin
            n_bin         = '0;
            n_band        = '0;
            n_sum         = '0;
            n_low         = '0;
            n_pend        = 1'b0;
            n_div_restart = 1'b1;
            n_div_start   = 1'b1;
            n_state       = S_DIV;
        end

        // output register
        if (w_out_load) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // control and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_DIV;
            r_after       <= AFT_IDLE;
            r_pend        <= 1'b0;
            r_div_restart <= 1'b1;
            r_div_start   <= 1'b1;
            r_log_start   <= 1'b0;
            r_o_valid     <= 1'b0;
            r_fft_log2    <= FFT_LOG2_RST;
            r_band_count  <= BAND_COUNT_RST;
            r_bin         <= '0;
            r_band        <= '0;
            r_sum         <= '0;
            r_low         <= '0;
            r_high        <= '0;
        end else begin
            r_state       <= n_state;
            r_after       <= n_after;
            r_pend        <= n_pend;
            r_div_restart <= n_div_restart;
            r_div_start   <= n_div_start;
            r_log_start   <= n_log_start;
            r_o_valid     <= n_o_valid;
            r_fft_log2    <= n_fft_log2;
            r_band_count  <= n_band_count;
            r_bin         <= n_bin;
            r_band        <= n_band;
            r_sum         <= n_sum;
            r_low         <= n_low;
            r_high        <= n_high;
        end
    end

    // band capture and decibel arithmetic
    always_ff @(posedge i_clk) begin
        if (w_em_load) begin
            r_e_idx  <= w_em_idx;
            r_e_sum  <= w_em_sum;
            r_e_cnt  <= w_em_cnt;
            r_e_zero <= w_em_zero;
            r_e_last <= w_em_last;
        end
        if (r_state == S_LOGS && w_log_done) begin
            r_log_s <= w_log_res;
        end
        if (r_state == S_LOGC && w_log_done) begin
            r_l <= $signed({2'b00, r_log_s}) - $signed({2'b00, w_log_res}) - L_OFS;
        end
        if (r_state == S_SCALE) begin
            r_prod <= r_l * K_S;
        end
    end

    // result transaction payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_idx   <= IDX_W'(r_e_idx);
            r_o_level <= w_level;
            r_o_zero  <= r_e_zero;
            r_o_last  <= r_e_last;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_band_index = r_o_idx;
    assign o_level_db   = r_o_level;
    assign o_level_zero = r_o_zero;
    assign o_last_band  = r_o_last;

`ifndef NO_ASSERTIONS
    // band edges rise strictly while bins are taken
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_high > r_low))
        else $error("band high edge not above low edge");

    // the bin counter never runs past the open band
    a_bin_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_bin <= r_high))
        else $error("bin counter beyond band high edge");

    // the open band is one of the configured bands
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_band < w_bands))
        else $error("band counter beyond band count");

    // a finished band close always reports a band
    a_close_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_close || w_last) && !i_cfg_we) |=> (r_state != S_IDLE))
        else $error("band close did not start a report");
`endif

endmodule

// File: tb/sv/spectrum_band_mean_db_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_band_mean_db_tb
// Streams fft magnitude frames into the band averager under several fft sizes
// and band counts, predicts every band level in q8.8 dB and checks each band
// result as it leaves, with random idling on both channels.
// ----------------------------------------------------------------------------
module spectrum_band_mean_db_tb;

    import sbm_pkg::*;

    // expected band levels, worked out from the accepted magnitudes
    class band_level_board;

        typedef struct packed {
            logic [IDX_W-1:0] band_index;
            logic [LVL_W-1:0] level_db;
            logic             level_zero;
            logic             last_band;
        } t_band_result;

        localparam int unsigned MAX_FFT = MAX_FFT_SIZE_DEF;

        logic [FFTL_W-1:0] fft_log2;
        logic [BAND_W-1:0] band_req;
        int unsigned       bin_pos;
        int unsigned       band_pos;
        int unsigned       low_edge;
        int unsigned       high_edge;
        longint unsigned   band_acc;
        t_band_result      expected_bands[$];
        int                errors;

        function new();
            errors = 0;
            fft_log2 = FFT_LOG2_RST;
            band_req = BAND_COUNT_RST;
            restart_frame();
        endfunction

        // bins per frame after clamping the fft size
        function int unsigned half_bins();
            int unsigned maxlog;
            int unsigned lg;
            maxlog = 0;
            lg = fft_log2;
            while (maxlog < 20 && (64'd2 << maxlog) <= MAX_FFT) maxlog++;
            if (maxlog < 3) maxlog = 3;
            if (lg < 3) lg = 3;
            if (lg > maxlog) lg = maxlog;
            return 1 << (lg - 1);
        endfunction

        function int unsigned bands_used();
            int unsigned b;
            b = band_req;
            if (b < 1) b = 1;
            if (b > half_bins()) b = half_bins();
            return b;
        endfunction

        function int unsigned band_edge(int unsigned k);
            return int'((longint'(k) * half_bins()) / bands_used());
        endfunction

        function void restart_frame();
            bin_pos = 0;
            band_pos = 0;
            band_acc = 0;
            low_edge = 0;
            high_edge = band_edge(1);
        endfunction

        // log2 with 20 fraction bits by normalize and repeated squaring
        function longint log2_fixed(longint unsigned x);
            int unsigned     e;
            longint unsigned m;
            longint unsigned frac;
            e = 63;
            frac = 0;
            while (e > 0 && x[e] == 1'b0) e--;
            m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
            for (int i = 0; i < LOG_FRAC; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= (64'd2 << 31)) begin
                    frac = frac | 64'd1;
                    m = m >> 1;
                end
            end
            return longint'((longint'(e) << LOG_FRAC) | frac);
        endfunction

        // mean of one band in q8.8 dB, queued as the next expected result
        function void queue_band_level(int unsigned idx, longint unsigned acc,
                                       int unsigned span, bit last);
            t_band_result    want;
            longint          l2;
            longint          prod;
            longint          level;
            longint unsigned mag;
            want.band_index = idx[IDX_W-1:0];
            want.last_band = last;
            if (acc == 0) begin
                level = -32768;
                want.level_zero = 1'b1;
            end else begin
                l2 = log2_fixed(acc) - log2_fixed(span)
                     - (longint'(SPEC_OFFSET) << LOG_FRAC);
                prod = l2 * longint'(DB_K);
                mag = (prod < 0) ? longint'(-prod) : prod;
                mag = (mag + (64'd1 << (DB_SHIFT - 1))) >> DB_SHIFT;
                if (mag > 40000) mag = 40000;
                level = (prod < 0) ? -longint'(mag) : longint'(mag);
                if (level > 32767) level = 32767;
                if (level < -32768) level = -32768;
                want.level_zero = 1'b0;
            end
            want.level_db = level[LVL_W-1:0];
            expected_bands.push_back(want);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FFT_SIZE_LOG2) fft_log2 = data[FFTL_W-1:0];
            else if (idx == REG_BAND_COUNT) band_req = data[BAND_W-1:0];
            else return;
            restart_frame();
        endfunction

        // one accepted magnitude transaction
        function void note_magnitude(logic [MAG_W-1:0] mag_in);
            int unsigned half;
            int unsigned bands;
            int unsigned i;
            half = half_bins();
            bands = bands_used();
            i = bin_pos;
            if (i >= 1) band_acc += mag_in;
            // edge bin closes this band and opens the next one
            if (band_pos + 1 < bands && i == high_edge) begin
                queue_band_level(band_pos, band_acc, high_edge - low_edge + 1, 1'b0);
                band_pos++;
                low_edge = high_edge;
                high_edge = band_edge(band_pos + 1);
                band_acc = (i >= 1) ? longint'(mag_in) : 0;
            end
            // final bin of the frame closes the last band
            if (i + 1 >= half) begin
                queue_band_level(band_pos, band_acc, high_edge - low_edge + 1, 1'b1);
                restart_frame();
            end else begin
                bin_pos = i + 1;
            end
        endfunction

        function int pending();
            return expected_bands.size();
        endfunction

        // one accepted band result transaction
        function void check_band(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] lvl,
                                 logic zero, logic last);
            t_band_result want;
            if (expected_bands.size() == 0) begin
                errors++;
                $display("%0t: unexpected band result, expected none, got index %0d level %0d",
                         $time, idx, $signed(lvl));
                return;
            end
            want = expected_bands.pop_front();
            if (idx !== want.band_index) begin
                errors++;
                $display("%0t: band_index expected %0d got %0d", $time, want.band_index, idx);
            end
            if (lvl !== want.level_db) begin
                errors++;
                $display("%0t: level_db of band %0d expected %0d got %0d", $time,
                         want.band_index, $signed(want.level_db), $signed(lvl));
            end
            if (zero !== want.level_zero) begin
                errors++;
                $display("%0t: level_zero of band %0d expected %0b got %0b", $time,
                         want.band_index, want.level_zero, zero);
            end
            if (last !== want.last_band) begin
                errors++;
                $display("%0t: last_band of band %0d expected %0b got %0b", $time,
                         want.band_index, want.last_band, last);
            end
        endfunction

    endclass

    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 1000000;

    // index past the register list, writes to it are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        MAG_FULL,
        MAG_SPARSE,
        MAG_TINY,
        MAG_HIGH,
        MAG_SCALED
    } t_mag_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [MAG_W-1:0]         i_magnitude = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [IDX_W-1:0]         o_band_index;
    logic signed [LVL_W-1:0]  o_level_db;
    logic                     o_level_zero;
    logic                     o_last_band;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       hold_left = 0;
    bit                       hold_done = 1'b0;
    int                       results_taken = 0;
    int                       cycles_run = 0;

    band_level_board          sb;

    spectrum_band_mean_db u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_magnitude  (i_magnitude),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_band_index (o_band_index),
        .o_level_db   (o_level_db),
        .o_level_zero (o_level_zero),
        .o_last_band  (o_last_band),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("FAIL spectrum_band_mean_db");
            $finish;
        end
    end

    // result side backpressure, with one long hold-off while input is offered
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) results_taken <= results_taken + 1;
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_taken >= HOLD_AT && i_valid) begin
                i_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_band(o_band_index, o_level_db, o_level_zero, o_last_band);
    end

    // offer one magnitude transaction and wait for it to be taken
    task automatic send_mag(input logic [MAG_W-1:0] mag_in);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_magnitude <= mag_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_magnitude(mag_in);
    endtask

    // register write once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        while (!o_ready) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering until every expected band has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [MAG_W-1:0] pick_magnitude(t_mag_mode mode);
        case (mode)
            MAG_SPARSE: return ($urandom_range(0, 99) < 97) ? 32'd0 : $urandom_range(1, 3);
            MAG_TINY:   return $urandom_range(0, 3);
            MAG_HIGH:   return 32'hFFFF_FFFF - $urandom_range(0, 255);
            MAG_SCALED: return $urandom() >> $urandom_range(0, 31);
            default:    return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        logic [MAG_W-1:0]      corner_frames [12];
        int                    sent_random;
        int                    seg_len;
        int                    kind;
        int unsigned           half_now;
        t_mag_mode             mode;
        logic [CFG_DATA_W-1:0] band_pick;

        corner_frames = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_FFFF};
        sent_random = 0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, band count clamped down to the number of bins in the frame
        write_reg(REG_FFT_SIZE_LOG2, 10'd0);
        write_reg(REG_BAND_COUNT, 10'd1023);
        foreach (corner_frames[k]) send_mag(corner_frames[k]);
        drain();

        // ignored register index leaves the frame running
        write_reg(REG_SPARE, 10'h3FF);
        send_mag(32'h1234_5678);
        send_mag(32'hFFFF_0000);
        drain();

        // band count zero clamps to a single band, dropping the open frame
        write_reg(REG_BAND_COUNT, 10'd0);
        repeat (4) send_mag(32'h0001_0000);
        drain();

        // largest fft with the most bands
        write_reg(REG_FFT_SIZE_LOG2, 10'd15);
        write_reg(REG_BAND_COUNT, 10'd1023);
        send_mag(32'h0001_0000);
        send_mag(32'h0000_0001);
        send_mag(32'hFFFF_FFFF);

        // random segments, each under a fresh setting
        while (sent_random < RANDOM_ITEMS) begin
            drain();
            kind = $urandom_range(0, 7);
            if (kind == 0) begin
                // wide bands of tiny bins, drives the level to its floor
                write_reg(REG_FFT_SIZE_LOG2, CFG_DATA_W'($urandom_range(7, 8)));
                write_reg(REG_BAND_COUNT, CFG_DATA_W'($urandom_range(1, 2)));
                mode = MAG_SPARSE;
                seg_len = sb.half_bins();
            end else begin
                case ($urandom_range(0, 9)) inside
                    [0:5]:   half_now = $urandom_range(3, 6);
                    6:       half_now = $urandom_range(7, 8);
                    7:       half_now = 10;
                    8:       half_now = ($urandom_range(0, 1) != 0) ? 15 : 0;
                    default: half_now = $urandom_range(0, 15);
                endcase
                if ($urandom_range(0, 3) != 1)
                    write_reg(REG_FFT_SIZE_LOG2, CFG_DATA_W'(half_now));
                case ($urandom_range(0, 7))
                    0:       band_pick = 10'd0;
                    1:       band_pick = 10'd1;
                    2:       band_pick = 10'd1023;
                    3:       band_pick = CFG_DATA_W'(sb.half_bins());
                    4:       band_pick = CFG_DATA_W'($urandom_range(0, 1023));
                    default: band_pick = CFG_DATA_W'($urandom_range(1, sb.half_bins()));
                endcase
                write_reg(REG_BAND_COUNT, band_pick);
                if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
                mode = t_mag_mode'($urandom_range(0, 4));
                half_now = sb.half_bins();
                if (half_now <= 64 && $urandom_range(0, 1) != 0)
                    seg_len = half_now * $urandom_range(1, 3);
                else
                    seg_len = $urandom_range(20, 90);
            end
            for (int n = 0; n < seg_len && sent_random < RANDOM_ITEMS; n++) begin
                // idle mix by third of the run
                if (sent_random < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 35;
                    recv_idle_pct <= 53;
                end else if (sent_random < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 53;
                    recv_idle_pct <= 35;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
                send_mag(pick_magnitude(mode));
                sent_random++;
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("PASS spectrum_band_mean_db");
        end else begin
            $display("FAIL spectrum_band_mean_db");
        end
        $finish;
    end

endmodule
